// ----- hw/rtl/ppa_pkg.sv -----
`default_nettype none

package ppa_pkg;

  localparam int RECORD_COUNT_DEF = 256;

  localparam int OPCODE_W    = 2;
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 32;
  localparam int PAGE_ADDR_W = 30;
  localparam int REUSE_W     = 32;
  localparam int PN_W        = 18;
  localparam int NEXT_W      = 31;
  localparam int PAGES_W     = 19;
  localparam int REGION_W    = 30;
  localparam int PAGE_SHIFT  = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [PAGES_W-1:0] TOP_PAGE_NUM = 19'h40000;
  localparam logic [PAGES_W-1:0] MIN_PAGES    = 19'd32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_CONTIG = 2'd1,
    OP_FREE   = 2'd2,
    OP_INIT   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_START = 1'b0,
    REG_REGION_PAGES = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic latch;
    logic init_apply;
    logic contig_apply;
    logic pop;
    logic scan_start;
    logic key_stack;
    logic scan_run;
    logic clr_run;
    logic apply;
    logic miss;
    logic fail;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic stack_empty;
    logic alloc_ready;
    logic free_addr_ok;
    logic hit;
    logic miss_end;
    logic clr_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ppa_in_if.sv -----
`default_nettype none

interface ppa_in_if;
  import ppa_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ADDR_W-1:0]   address;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output opcode, output address, output count, input ready);
  modport sink   (input valid, input opcode, input address, input count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ppa_out_if.sv -----
`default_nettype none

interface ppa_out_if;
  import ppa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [PAGE_ADDR_W-1:0] page_address;
  logic [REUSE_W-1:0]     reuse_count;

  modport source (output valid, output ok, output page_address, output reuse_count, input ready);
  modport sink   (input valid, input ok, input page_address, input reuse_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ppa_cfg_if.sv -----
`default_nettype none

interface ppa_cfg_if;
  import ppa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/physical_page_allocator_core.sv -----
// Page allocator for memory below 1 GiB with 4096-byte pages.
// The in_if channel carries one operation per transaction: allocate a page,
// allocate a contiguous run, free a page, or initialize. The out_if channel
// returns exactly one result per operation: ok, the page address, and the
// running count of allocations served from the free stack.
// The cfg_if channel writes region_start (index 0) and region_pages
// (index 1). It is always ready; write it only while no operation is pending.
// One operation is processed at a time. Contiguous allocation and refusals
// decided from the operands go from acceptance through an execute state and a
// response state to out_if.valid. Single-page allocate and free scan the record
// table at one entry per cycle through its single read port, with a free-stack
// read before the scan on reuse. Initialize rewrites the table at one entry per
// cycle.
// After reset the block clears the record table with in_if.ready low; all
// counters and pointers start at zero.
// A finished result sits in an output register until the receiver takes it.
// The next operation may be accepted meanwhile, but its result waits until the
// register is free, so a stalled receiver stalls the block.
`default_nettype none

module physical_page_allocator_core #(
  parameter int RECORD_COUNT = ppa_pkg::RECORD_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ppa_in_if.sink   in_if,
  ppa_out_if.source out_if,
  ppa_cfg_if.sink  cfg_if
);
  import ppa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_if.ready = 1'b1;

  ppa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppa_datapath #(
    .RECORD_COUNT (RECORD_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_if.opcode),
    .in_address       (in_if.address),
    .in_count         (in_if.count),
    .cfg_we           (cfg_if.valid && cfg_if.ready),
    .cfg_index        (cfg_if.index),
    .cfg_data         (cfg_if.data),
    .out_ok           (out_if.ok),
    .out_page_address (out_if.page_address),
    .out_reuse_count  (out_if.reuse_count)
  );

  a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted while an operation was already in progress");

  a_idle_no_table_access: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> (!cmd.scan_run && !cmd.clr_run && !cmd.apply))
    else $error("record table accessed while the block is idle");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_if.valid || out_if.ready))
    else $error("result register overwritten before it was taken");

  a_hit_miss_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.hit && sts.miss_end))
    else $error("record scan reported both a hit and a miss");

endmodule

`default_nettype wire

// ----- hw/rtl/ppa_ctrl.sv -----
`default_nettype none

module ppa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire ppa_pkg::dp_sts_t sts,
  output ppa_pkg::dp_cmd_t      cmd
);
  import ppa_pkg::*;

  typedef enum logic [6:0] {
    S_WIPE = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_POPW = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_CLR  = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_WIPE: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_INIT: begin
            cmd.init_apply = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = S_CLR;
          end
          OP_CONTIG: begin
            cmd.contig_apply = 1'b1;
            state_nxt        = S_RESP;
          end
          OP_FREE: begin
            if (sts.free_addr_ok) begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end else begin
              cmd.fail  = 1'b1;
              state_nxt = S_RESP;
            end
          end
          OP_ALLOC: begin
            priority if (!sts.stack_empty) begin
              cmd.pop   = 1'b1;
              state_nxt = S_POPW;
            end else if (sts.alloc_ready) begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end else begin
              cmd.fail  = 1'b1;
              state_nxt = S_RESP;
            end
          end
          default: begin
            cmd.fail  = 1'b1;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_POPW: begin
        cmd.scan_start = 1'b1;
        cmd.key_stack  = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = !sts.hit;
        if (sts.hit) begin
          cmd.apply = 1'b1;
          state_nxt = S_RESP;
        end else if (sts.miss_end) begin
          cmd.miss  = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_CLR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_WIPE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ppa_datapath.sv -----
`default_nettype none

module ppa_datapath #(
  parameter int RECORD_COUNT = ppa_pkg::RECORD_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ppa_pkg::dp_cmd_t                cmd,
  output ppa_pkg::dp_sts_t                     sts,
  input  wire logic [ppa_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire logic [ppa_pkg::ADDR_W-1:0]      in_address,
  input  wire logic [ppa_pkg::COUNT_W-1:0]     in_count,
  input  wire logic                            cfg_we,
  input  wire logic [ppa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ppa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 out_ok,
  output logic [ppa_pkg::PAGE_ADDR_W-1:0]      out_page_address,
  output logic [ppa_pkg::REUSE_W-1:0]          out_reuse_count
);
  import ppa_pkg::*;

  localparam int IDX_W = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
  localparam int CNT_W = $clog2(RECORD_COUNT + 1);
  localparam logic [CNT_W-1:0] REC_N    = CNT_W'(RECORD_COUNT);
  localparam logic [CNT_W-1:0] REC_LAST = CNT_W'(RECORD_COUNT - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RECORD_COUNT - 1);

  typedef struct packed {
    logic [PN_W-1:0] pn;
    logic            live;
  } rec_t;

  rec_t            rec_mem [RECORD_COUNT];
  logic [PN_W-1:0] stk_mem [RECORD_COUNT];

  logic [REGION_W-1:0]    region_start_r;
  logic [PAGES_W-1:0]     region_pages_r;
  op_t                    op_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [COUNT_W-1:0]     count_r;
  logic [NEXT_W-1:0]      next_r;
  logic [PAGES_W-1:0]     pages_left_r;
  logic [CNT_W-1:0]       depth_r;
  logic [REUSE_W-1:0]     reuse_r;
  logic [CNT_W-1:0]       scan_idx_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   rvld_r;
  rec_t                   rdata_r;
  logic [PN_W-1:0]        stk_rdata_r;
  logic [PN_W-1:0]        key_r;
  logic                   pop_mode_r;
  logic                   res_ok_r;
  logic [PAGE_ADDR_W-1:0] res_page_r;
  logic                   out_ok_r;
  logic [PAGE_ADDR_W-1:0] out_page_r;
  logic [REUSE_W-1:0]     out_reuse_r;

  logic                   issue;
  logic                   match;
  logic [CNT_W-1:0]       depth_dec;
  logic [PAGES_W-1:0]     room_init;
  logic [PAGES_W-1:0]     pages_init;
  logic [PAGES_W-1:0]     room_now;
  logic                   contig_ok;
  logic                   rec_we;
  logic [IDX_W-1:0]       rec_waddr;
  rec_t                   rec_wdata;
  logic                   push;

  assign issue     = cmd.scan_run && (scan_idx_r < REC_N);
  assign match     = (rdata_r.pn == key_r) && ((key_r != '0) || !rdata_r.live);
  assign depth_dec = depth_r - CNT_W'(1);

  assign room_init  = TOP_PAGE_NUM - {1'b0, region_start_r[REGION_W-1:PAGE_SHIFT]};
  assign pages_init = (region_pages_r > room_init) ? room_init : region_pages_r;
  assign room_now   = TOP_PAGE_NUM - {1'b0, next_r[PAGE_ADDR_W-1:PAGE_SHIFT]};
  assign contig_ok  = (count_r != '0) && (count_r <= COUNT_W'(pages_left_r)) &&
                      (next_r != '0) && !next_r[NEXT_W-1] &&
                      (count_r[PAGES_W-1:0] <= room_now);

  assign push = cmd.apply && !pop_mode_r && (op_r == OP_FREE) && rdata_r.live &&
                (depth_r < REC_N);

  always_comb begin
    sts              = '0;
    sts.op           = op_r;
    sts.stack_empty  = (depth_r == '0);
    sts.alloc_ready  = (pages_left_r != '0) && (next_r != '0) && !next_r[NEXT_W-1];
    sts.free_addr_ok = (addr_r != '0) && (addr_r[PAGE_SHIFT-1:0] == '0) &&
                       (addr_r[ADDR_W-1:PAGE_ADDR_W] == '0);
    sts.hit          = rvld_r && match;
    sts.miss_end     = rvld_r && !match && (cmp_idx_r == IDX_LAST);
    sts.clr_last     = (scan_idx_r == REC_LAST);
  end

  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = cmp_idx_r;
    rec_wdata = '0;
    priority if (cmd.clr_run) begin
      rec_we    = 1'b1;
      rec_waddr = scan_idx_r[IDX_W-1:0];
    end else if (cmd.apply) begin
      priority if (pop_mode_r) begin
        rec_we    = 1'b1;
        rec_wdata = '{pn: key_r, live: 1'b1};
      end else if (op_r == OP_FREE) begin
        rec_we    = rdata_r.live;
        rec_wdata = '{pn: key_r, live: 1'b0};
      end else begin
        rec_we    = 1'b1;
        rec_wdata = '{pn: next_r[PAGE_ADDR_W-1:PAGE_SHIFT], live: 1'b1};
      end
    end else begin
      rec_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (issue) begin
      rdata_r   <= rec_mem[scan_idx_r[IDX_W-1:0]];
      cmp_idx_r <= scan_idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[depth_r[IDX_W-1:0]] <= key_r;
    end
    if (cmd.pop) begin
      stk_rdata_r <= stk_mem[depth_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_pages_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_REGION_START: region_start_r <= cfg_data[REGION_W-1:0];
        REG_REGION_PAGES: region_pages_r <= cfg_data[PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rvld_r     <= 1'b0;
    end else begin
      rvld_r <= issue;
      priority if (cmd.scan_start) begin
        scan_idx_r <= '0;
      end else if (cmd.clr_run || issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end else begin
        scan_idx_r <= scan_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r       <= '0;
      pages_left_r <= '0;
      depth_r      <= '0;
      reuse_r      <= '0;
    end else begin
      if (cmd.init_apply) begin
        next_r       <= {1'b0, region_start_r[REGION_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        pages_left_r <= pages_init;
        depth_r      <= '0;
        reuse_r      <= '0;
      end
      if (cmd.contig_apply && contig_ok) begin
        next_r       <= next_r + {count_r[PAGES_W-1:0], {PAGE_SHIFT{1'b0}}};
        pages_left_r <= pages_left_r - count_r[PAGES_W-1:0];
      end
      if (cmd.pop) begin
        depth_r <= depth_dec;
        reuse_r <= reuse_r + REUSE_W'(1);
      end
      if (cmd.apply && !pop_mode_r && (op_r != OP_FREE)) begin
        next_r       <= next_r + NEXT_W'(1 << PAGE_SHIFT);
        pages_left_r <= pages_left_r - PAGES_W'(1);
      end
      if (push) begin
        depth_r <= depth_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= op_t'(in_opcode);
      addr_r  <= in_address;
      count_r <= in_count;
    end
    if (cmd.scan_start) begin
      priority if (cmd.key_stack) begin
        key_r      <= stk_rdata_r;
        pop_mode_r <= 1'b1;
        res_ok_r   <= 1'b1;
        res_page_r <= {stk_rdata_r, {PAGE_SHIFT{1'b0}}};
      end else if (op_r == OP_FREE) begin
        key_r      <= addr_r[PAGE_ADDR_W-1:PAGE_SHIFT];
        pop_mode_r <= 1'b0;
      end else begin
        key_r      <= '0;
        pop_mode_r <= 1'b0;
      end
    end
    if (cmd.init_apply) begin
      res_ok_r   <= (region_start_r[REGION_W-1:PAGE_SHIFT] != '0) && (pages_init >= MIN_PAGES);
      res_page_r <= '0;
    end
    if (cmd.contig_apply) begin
      res_ok_r   <= contig_ok;
      res_page_r <= contig_ok ? next_r[PAGE_ADDR_W-1:0] : '0;
    end
    if (cmd.fail || (cmd.miss && !pop_mode_r)) begin
      res_ok_r   <= 1'b0;
      res_page_r <= '0;
    end
    if (cmd.apply && !pop_mode_r) begin
      if (op_r == OP_FREE) begin
        res_ok_r   <= rdata_r.live;
        res_page_r <= '0;
      end else begin
        res_ok_r   <= 1'b1;
        res_page_r <= next_r[PAGE_ADDR_W-1:0];
      end
    end
    if (cmd.out_load) begin
      out_ok_r    <= res_ok_r;
      out_page_r  <= res_page_r;
      out_reuse_r <= reuse_r;
    end
  end

  assign out_ok           = out_ok_r;
  assign out_page_address = out_page_r;
  assign out_reuse_count  = out_reuse_r;

endmodule

`default_nettype wire
